@@ rtl/csbp_pkg.sv @@
// shared widths, codes and defaults for the code/symbol bit packer
`default_nettype none

package csbp_pkg;

  // fixed field widths
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;

  // default longest code that is packed
  localparam int MAX_CODE_BITS_DEF = 16;

  // item kinds carried on tuser
  typedef enum logic {
    OP_PACK  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

endpackage

`default_nettype wire

@@ rtl/csbp_calc.sv @@
// merges pending bits with one code/symbol pair and splits off the whole bytes, or flushes the pending bits
`default_nettype none

module csbp_calc
  import csbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int ACC_W         = PEND_W + MAX_CODE_BITS + SYM_W,
  parameter int MAX_BYTES     = ACC_W / BYTE_W,
  parameter int BCNT_W        = $clog2(MAX_BYTES + 1)
) (
  input  var op_t                        op,
  input  wire logic [CODE_W-1:0]         code,
  input  wire logic [LEN_W-1:0]          code_len,
  input  wire logic [SYM_W-1:0]          sym,
  input  wire logic [PEND_W-1:0]         pend_bits,
  input  wire logic [PCNT_W-1:0]         pend_cnt,
  output logic [MAX_BYTES*BYTE_W-1:0]    bytes,
  output logic [BCNT_W-1:0]              nbytes,
  output logic [PEND_W-1:0]              pend_bits_next,
  output logic [PCNT_W-1:0]              pend_cnt_next
);

  localparam int NB_W = $clog2(ACC_W + 1);

  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_masked;
  logic [NB_W-1:0]   sym_pos;
  logic [NB_W-1:0]   nbits;
  logic [BCNT_W-1:0] nbytes_pair;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  rest;

  // clamp the code length and drop code bits above it
  always_comb begin
    if (code_len > LEN_W'(MAX_CODE_BITS)) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = code_len;
    end
    for (int i = 0; i < CODE_W; i++) begin
      code_masked[i] = code[i] && (LEN_W'(i) < len_sat);
    end
  end

  // bit string: pending, then code, then symbol
  assign sym_pos     = NB_W'(pend_cnt) + NB_W'(len_sat);
  assign nbits       = sym_pos + NB_W'(SYM_W);
  assign nbytes_pair = BCNT_W'(nbits >> 3);
  assign acc         = ACC_W'(pend_bits)
                     | (ACC_W'(code_masked) << pend_cnt)
                     | (ACC_W'(sym) << sym_pos);
  assign rest        = acc >> (NB_W'(nbytes_pair) << 3);

  // select pair or flush result
  always_comb begin
    unique case (op)
      OP_FLUSH: begin
        bytes          = (MAX_BYTES*BYTE_W)'(pend_bits);
        nbytes         = BCNT_W'(1);
        pend_bits_next = '0;
        pend_cnt_next  = '0;
      end
      default: begin
        bytes          = acc[MAX_BYTES*BYTE_W-1:0];
        nbytes         = nbytes_pair;
        pend_bits_next = rest[PEND_W-1:0];
        pend_cnt_next  = nbits[PCNT_W-1:0];
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/code_symbol_bit_packer_unit.sv @@
// top level of the lsb-first code/symbol bit packer
// Packs code/symbol pairs into a byte stream, least significant bit first.
// Input channel s_*: one beat per item. tuser[0] is the kind (0 = pair,
// 1 = flush). tdata carries code, code_len and sym. A pair appends the low
// code_len bits of code (length clamped to MAX_CODE_BITS) and then the
// 8 symbol bits to the pending bits; every completed byte goes out.
// A flush always sends one byte with the pending bits, zero padded, and
// clears them.
// Output channel m_*: one byte per beat, tlast on the final byte of an item.
// Path: an accepted item goes through the input register, then the byte
// register, before its first byte is valid on the output channel.
// Throughput: one byte per cycle while m_tready is high; a pair gives
// 1 to 3 bytes and a flush one byte. The byte register that feeds the
// output channel sets this.
// Reset (rst, synchronous) empties both registers and clears pending bits.
// When the receiver stalls, the byte register holds its beat, the input
// register fills behind it, and then s_tready drops; nothing is lost.
`default_nettype none

module code_symbol_bit_packer_unit
  import csbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // code [15:0], code_len [20:16], sym [28:21], zero
  input  wire logic [0:0]  s_tuser,   // op [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte [7:0]
  output logic             m_tlast
);

  localparam int ACC_W     = PEND_W + MAX_CODE_BITS + SYM_W;
  localparam int MAX_BYTES = ACC_W / BYTE_W;
  localparam int BCNT_W    = $clog2(MAX_BYTES + 1);
  localparam int BUF_W     = MAX_BYTES * BYTE_W;

  // input register
  logic              in_valid;
  op_t               in_op;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [SYM_W-1:0]  in_sym;

  // pending bits and byte register
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;
  logic [BUF_W-1:0]  pk_bytes;
  logic [BCNT_W-1:0] pk_cnt;

  logic [BUF_W-1:0]  calc_bytes;
  logic [BCNT_W-1:0] calc_nbytes;
  logic [PEND_W-1:0] pend_bits_next;
  logic [PCNT_W-1:0] pend_cnt_next;

  logic s_beat;
  logic m_beat;
  logic load;

  // handshakes
  assign m_tvalid = (pk_cnt != '0);
  assign m_tdata  = pk_bytes[BYTE_W-1:0];
  assign m_tlast  = (pk_cnt == BCNT_W'(1));
  assign m_beat   = m_tvalid && m_tready;
  assign load     = in_valid && ((pk_cnt == '0) || (m_tlast && m_tready));
  assign s_tready = !in_valid || load;
  assign s_beat   = s_tvalid && s_tready;

  csbp_calc #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .ACC_W         (ACC_W),
    .MAX_BYTES     (MAX_BYTES),
    .BCNT_W        (BCNT_W)
  ) u_calc (
    .op             (in_op),
    .code           (in_code),
    .code_len       (in_len),
    .sym            (in_sym),
    .pend_bits      (pend_bits),
    .pend_cnt       (pend_cnt),
    .bytes          (calc_bytes),
    .nbytes         (calc_nbytes),
    .pend_bits_next (pend_bits_next),
    .pend_cnt_next  (pend_cnt_next)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_op   <= op_t'(s_tuser[0]);
      in_code <= s_tdata[15:0];
      in_len  <= s_tdata[20:16];
      in_sym  <= s_tdata[28:21];
    end
  end

  // pending bits and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
      pk_cnt    <= '0;
    end else if (load) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
      pk_cnt    <= calc_nbytes;
    end else if (m_beat) begin
      pk_cnt    <= pk_cnt - BCNT_W'(1);
    end
  end

  // byte register payload
  always_ff @(posedge clk) begin
    if (load) begin
      pk_bytes <= calc_bytes;
    end else if (m_beat) begin
      pk_bytes <= pk_bytes >> BYTE_W;
    end
  end

endmodule

`default_nettype wire
